// ===== rtl/core/checksummed_sentence_formatter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the checksummed sentence formatter
// Concurrent assertion wrappers on the block clock, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_SENTENCE_FORMATTER_ASSERT_SVH
`define CHECKSUMMED_SENTENCE_FORMATTER_ASSERT_SVH

// Checked only while out of reset.
`define CSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/csf_pkg.sv =====
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, character codes and helper functions of the sentence formatter.
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam int unsigned NUM_SLOTS = 14;

  localparam logic [13:0] VALUE_MAX = 14'd9999;
  localparam logic [23:0] TAG_RESET = 24'h494D55;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [3:0] CH_DIGIT_HI = 4'h3;

  // Character positions of one item, in the order they are sent.
  typedef enum logic [3:0] {
    SLOT_DOLLAR = 4'd0,
    SLOT_TAG0   = 4'd1,
    SLOT_TAG1   = 4'd2,
    SLOT_TAG2   = 4'd3,
    SLOT_COMMA  = 4'd4,
    SLOT_D3     = 4'd5,
    SLOT_D2     = 4'd6,
    SLOT_D1     = 4'd7,
    SLOT_D0     = 4'd8,
    SLOT_STAR   = 4'd9,
    SLOT_HEXH   = 4'd10,
    SLOT_HEXL   = 4'd11,
    SLOT_CR     = 4'd12,
    SLOT_LF     = 4'd13
  } slot_t;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // One item after decimal conversion.
  typedef struct packed {
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
    logic       first;
    logic       last;
  } desc_t;

  // Largest k in 0..9 with k * unit <= v; parallel compares only.
  function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [13:0] unit);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 14'(k) * unit) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = {CH_DIGIT_HI, n};
    end else begin
      c = 8'h37 + {4'h0, n};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/checksummed_sentence_formatter.sv =====
// An item goes through the input register, stage B, the serializer's item and mask
// registers and the output register. One character per cycle while out_stall is low,
// set by the single character output register; an item gives 2 to 14 characters, and
// items follow without gaps when ready. Reset (synchronous, active low) empties the
// pipeline, clears the checksum to zero and loads the tag register with "IMU".
// ----------------------------------------------------------------------------
// checksummed_sentence_formatter
// Formats sample values into an ASCII sentence with an XOR checksum trailer.
// ----------------------------------------------------------------------------
module checksummed_sentence_formatter import csf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_sentence_tag,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_sample_value,
  input  logic        in_first_value,
  input  logic        in_last_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_end_of_run
);

  logic [23:0] tag_r;
  logic        desc_valid;
  logic        desc_take;
  desc_t       desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= TAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tag_r <= cfg_sentence_tag;
    end
  end

  csf_bcd u_bcd (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_first_value  (in_first_value),
    .in_last_value   (in_last_value),
    .desc_valid      (desc_valid),
    .desc            (desc),
    .desc_take       (desc_take)
  );

  csf_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .tag            (tag_r),
    .desc_valid     (desc_valid),
    .desc           (desc),
    .desc_take      (desc_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_end_of_run (out_end_of_run)
  );

endmodule

// ===== rtl/core/csf_bcd.sv =====
// ----------------------------------------------------------------------------
// csf_bcd
// Input register and two-stage decimal split of the saturated sample value.
// ----------------------------------------------------------------------------
module csf_bcd import csf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_sample_value,
  input  logic        in_first_value,
  input  logic        in_last_value,
  output logic        desc_valid,
  output desc_t       desc,
  input  logic        desc_take
);

  logic        a_valid_r;
  logic [13:0] a_value_r;
  logic        a_first_r;
  logic        a_last_r;

  logic        b_valid_r;
  logic [3:0]  b_d3_r;
  logic [3:0]  b_d2_r;
  logic [6:0]  b_rem_r;
  logic        b_first_r;
  logic        b_last_r;

  logic        a_en;
  logic        b_en;
  logic        in_take;
  logic [13:0] in_sat;
  logic [3:0]  d3;
  logic [3:0]  d2;
  logic [3:0]  d1;
  logic [13:0] r3_full;
  logic [9:0]  r3;
  logic [9:0]  r2_full;
  logic [6:0]  r1_full;

  assign b_en     = !b_valid_r || desc_take;
  assign a_en     = !a_valid_r || b_en;
  assign in_stall = !a_en;
  assign in_take  = in_valid && a_en;
  assign in_sat   = (in_sample_value > VALUE_MAX) ? VALUE_MAX : in_sample_value;

  // Thousands and hundreds between the input register and stage B.
  always_comb begin
    d3      = dec_digit(a_value_r, 14'd1000);
    r3_full = a_value_r - 14'(d3) * 14'd1000;
    r3      = r3_full[9:0];
    d2      = dec_digit({4'h0, r3}, 14'd100);
    r2_full = r3 - 10'(d2) * 10'd100;
  end

  // Tens and units after stage B.
  always_comb begin
    d1      = dec_digit({7'h00, b_rem_r}, 14'd10);
    r1_full = b_rem_r - 7'(d1) * 7'd10;
    desc.d3    = b_d3_r;
    desc.d2    = b_d2_r;
    desc.d1    = d1;
    desc.d0    = r1_full[3:0];
    desc.first = b_first_r;
    desc.last  = b_last_r;
  end

  assign desc_valid = b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_r <= in_valid;
      end
      if (b_en) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_value_r <= in_sat;
      a_first_r <= in_first_value;
      a_last_r  <= in_last_value;
    end
    if (b_en && a_valid_r) begin
      b_d3_r    <= d3;
      b_d2_r    <= d2;
      b_rem_r   <= r2_full[6:0];
      b_first_r <= a_first_r;
      b_last_r  <= a_last_r;
    end
  end

endmodule

// ===== rtl/core/csf_serializer.sv =====
// ----------------------------------------------------------------------------
// csf_serializer
// Sends the characters of one item, one per cycle unless stalled, and keeps the XOR checksum.
// ----------------------------------------------------------------------------
module csf_serializer import csf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [23:0] tag,
  input  logic        desc_valid,
  input  desc_t       desc,
  output logic        desc_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_end_of_run
);

  slot_mask_t mask_r;
  slot_mask_t mask_nxt;
  desc_t      item_r;
  logic [7:0] xor_r;
  logic [7:0] xor_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_eor_r;

  slot_t      sel;
  slot_mask_t rest;
  slot_mask_t mask_new;
  logic       has;
  logic       out_free;
  logic       emit;
  logic       load;
  logic [7:0] ch;

  assign has      = |mask_r;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = has && out_free;

  // Lowest pending character position.
  always_comb begin
    sel = SLOT_LF;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = slot_t'(4'(i));
      end
    end
  end

  assign rest      = mask_r & ~(slot_mask_t'(1) << sel);
  assign desc_take = !has || (emit && (rest == '0));
  assign load      = desc_take && desc_valid;

  // Leading zeros are dropped; the units digit is always sent.
  always_comb begin
    mask_new = '0;
    mask_new[SLOT_DOLLAR] = desc.first;
    mask_new[SLOT_TAG0]   = desc.first;
    mask_new[SLOT_TAG1]   = desc.first;
    mask_new[SLOT_TAG2]   = desc.first;
    mask_new[SLOT_COMMA]  = 1'b1;
    mask_new[SLOT_D3]     = (desc.d3 != 4'h0);
    mask_new[SLOT_D2]     = (desc.d3 != 4'h0) || (desc.d2 != 4'h0);
    mask_new[SLOT_D1]     = (desc.d3 != 4'h0) || (desc.d2 != 4'h0) || (desc.d1 != 4'h0);
    mask_new[SLOT_D0]     = 1'b1;
    mask_new[SLOT_STAR]   = desc.last;
    mask_new[SLOT_HEXH]   = desc.last;
    mask_new[SLOT_HEXL]   = desc.last;
    mask_new[SLOT_CR]     = desc.last;
    mask_new[SLOT_LF]     = desc.last;
  end

  always_comb begin
    if (load) begin
      mask_nxt = mask_new;
    end else if (emit) begin
      mask_nxt = rest;
    end else begin
      mask_nxt = mask_r;
    end
  end

  // The trailer reads the checksum after every summed character has been folded in.
  always_comb begin
    xor_nxt = xor_r;
    case (sel)
      SLOT_DOLLAR: begin
        ch      = CH_DOLLAR;
        xor_nxt = 8'h00;
      end
      SLOT_TAG0: begin
        ch      = tag[23:16];
        xor_nxt = xor_r ^ ch;
      end
      SLOT_TAG1: begin
        ch      = tag[15:8];
        xor_nxt = xor_r ^ ch;
      end
      SLOT_TAG2: begin
        ch      = tag[7:0];
        xor_nxt = xor_r ^ ch;
      end
      SLOT_COMMA: begin
        ch      = CH_COMMA;
        xor_nxt = xor_r ^ ch;
      end
      SLOT_D3: begin
        ch      = {CH_DIGIT_HI, item_r.d3};
        xor_nxt = xor_r ^ ch;
      end
      SLOT_D2: begin
        ch      = {CH_DIGIT_HI, item_r.d2};
        xor_nxt = xor_r ^ ch;
      end
      SLOT_D1: begin
        ch      = {CH_DIGIT_HI, item_r.d1};
        xor_nxt = xor_r ^ ch;
      end
      SLOT_D0: begin
        ch      = {CH_DIGIT_HI, item_r.d0};
        xor_nxt = xor_r ^ ch;
      end
      SLOT_STAR: ch = CH_STAR;
      SLOT_HEXH: ch = hex_char(xor_r[7:4]);
      SLOT_HEXL: ch = hex_char(xor_r[3:0]);
      SLOT_CR:   ch = CH_CR;
      SLOT_LF:   ch = CH_LF;
      default:   ch = CH_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      xor_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (emit) begin
        xor_r       <= xor_nxt;
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= desc;
    end
    if (emit) begin
      out_char_r <= ch;
      out_eor_r  <= (rest == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_end_of_run = out_eor_r;

endmodule

// ===== rtl/core/csf_checker.sv =====
// ----------------------------------------------------------------------------
// csf_checker
// Port-level checks of the sentence formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "checksummed_sentence_formatter_assert.svh"

module csf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_end_of_run
);

  // A stalled transaction keeps its character.
  `CSF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_end_of_run), "stalled output changed")

  // Every item ends on its units digit or on the line feed of the trailer.
  `CSF_ASSERT(a_end_char, out_valid && out_end_of_run |-> (out_char == 8'h0A) || ((out_char >= 8'h30) && (out_char <= 8'h39)), "item ends on an unexpected character")

  // Each item gives at least two characters, so two ends cannot follow each other.
  `CSF_ASSERT(a_two_chars, out_valid && !out_stall && out_end_of_run |=> !(out_valid && out_end_of_run), "item with a single character")

  // Nothing is shown in the cycle after reset.
  `CSF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind checksummed_sentence_formatter csf_checker u_csf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char       (out_char),
  .out_end_of_run (out_end_of_run)
);
